// ===== sv/necirfd_pkg.sv =====
package necirfd_pkg;

   localparam int unsigned DUR_W     = 15;
   localparam int unsigned HALF_W    = 16;
   localparam int unsigned CFG_NUM   = 8;
   localparam int unsigned CFG_IDX_W = 3;
   localparam int unsigned COUNT_W   = 6;
   localparam int unsigned STATUS_W  = 2;

   localparam logic [COUNT_W-1:0] FRAME_SYMBOLS  = 6'd34;
   localparam logic [COUNT_W-1:0] REPEAT_SYMBOLS = 6'd2;
   localparam logic [COUNT_W-1:0] BIT_SYMBOLS    = 6'd32;
   localparam logic [COUNT_W-1:0] COUNT_MAX      = 6'd63;

   typedef enum logic [CFG_IDX_W-1:0] {
      CFG_MARGIN       = 3'd0,
      CFG_LEAD_MARK    = 3'd1,
      CFG_LEAD_SPACE   = 3'd2,
      CFG_REPEAT_MARK  = 3'd3,
      CFG_REPEAT_SPACE = 3'd4,
      CFG_BIT_MARK     = 3'd5,
      CFG_ZERO_SPACE   = 3'd6,
      CFG_ONE_SPACE    = 3'd7
   } cfg_index_type;

   typedef logic [DUR_W-1:0] dur_type;

   localparam dur_type CFG_RESET [CFG_NUM] = '{
      15'd200, 15'd9000, 15'd4500, 15'd9000, 15'd2250, 15'd560, 15'd560, 15'd1690
   };

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DECODED  = 2'd0,
      STATUS_REPEAT   = 2'd1,
      STATUS_REJECTED = 2'd2
   } status_type;

   // classified symbol as it travels from front to back
   typedef struct packed {
      logic lead_ok;
      logic repeat_ok;
      logic one_ok;
      logic zero_ok;
      logic frame_end;
   } symbol_class_type;

   // lo < d < n + m, lo = n - m clamped at 0; d > n - m is tested as d + m > n
   function automatic logic fits(input dur_type d, input dur_type n, input dur_type m);
      logic [DUR_W:0] hi;
      logic [DUR_W:0] d_plus_m;
      logic           lt_hi;
      logic           gt_lo;
      hi       = {1'b0, n} + {1'b0, m};
      d_plus_m = {1'b0, d} + {1'b0, m};
      lt_hi    = {1'b0, d} < hi;
      gt_lo    = (n > m) ? (d_plus_m > {1'b0, n}) : (d != '0);
      return lt_hi && gt_lo;
   endfunction

endpackage

// ===== sv/necirfd_front.sv =====
module necirfd_front
   import necirfd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CFG_IDX_W-1:0] csr_index,
   input  logic [DUR_W-1:0]     csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [DUR_W-1:0]     req_mark_ticks,
   input  logic [DUR_W-1:0]     req_space_ticks,
   input  logic                 req_frame_end,
   input  logic                 q_full,
   output logic                 push_valid,
   output symbol_class_type     push_data
);

   dur_type cfg_ff [CFG_NUM];
   dur_type cfg_in [CFG_NUM];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         cfg_in[csr_index] = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_ready  = !q_full;
   assign push_valid = req_valid && !q_full;

   // all pair checks in parallel; the back decides which one counts
   always_comb begin
      push_data.lead_ok   = fits(req_mark_ticks, cfg_ff[CFG_LEAD_MARK], cfg_ff[CFG_MARGIN])
                         && fits(req_space_ticks, cfg_ff[CFG_LEAD_SPACE], cfg_ff[CFG_MARGIN]);
      push_data.repeat_ok = fits(req_mark_ticks, cfg_ff[CFG_REPEAT_MARK], cfg_ff[CFG_MARGIN])
                         && fits(req_space_ticks, cfg_ff[CFG_REPEAT_SPACE],
                                 cfg_ff[CFG_MARGIN]);
      push_data.one_ok    = fits(req_mark_ticks, cfg_ff[CFG_BIT_MARK], cfg_ff[CFG_MARGIN])
                         && fits(req_space_ticks, cfg_ff[CFG_ONE_SPACE], cfg_ff[CFG_MARGIN]);
      push_data.zero_ok   = fits(req_mark_ticks, cfg_ff[CFG_BIT_MARK], cfg_ff[CFG_MARGIN])
                         && fits(req_space_ticks, cfg_ff[CFG_ZERO_SPACE], cfg_ff[CFG_MARGIN]);
      push_data.frame_end = req_frame_end;
   end

endmodule

// ===== sv/necirfd_queue.sv =====
module necirfd_queue #(
   parameter int unsigned DEPTH = 4,
   parameter int unsigned WIDTH = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count lost a push");

endmodule

// ===== sv/necirfd_back.sv =====
module necirfd_back
   import necirfd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  symbol_class_type    q_data,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [HALF_W-1:0]   rsp_address,
   output logic [HALF_W-1:0]   rsp_command
);

   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [2*HALF_W-1:0] shift_ff, shift_in;
   logic                err_ff, err_in;
   logic                rep_ff, rep_in;
   logic [HALF_W-1:0]   last_addr_ff, last_addr_in;
   logic [HALF_W-1:0]   last_cmd_ff, last_cmd_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          status_ff, status_in;
   logic [HALF_W-1:0]   addr_ff, addr_in;
   logic [HALF_W-1:0]   cmd_ff, cmd_in;
   logic [COUNT_W-1:0]  len;
   logic [COUNT_W-1:0]  bit_idx;

   // a closing symbol needs a free output slot, other symbols never wait
   assign q_pop = q_valid && (!q_data.frame_end || !rsp_valid_ff || rsp_ready);

   assign bit_idx = count_ff - 1'b1;
   assign len     = (count_ff < COUNT_MAX) ? count_ff + 1'b1 : COUNT_MAX;

   always_comb begin
      count_in     = count_ff;
      shift_in     = shift_ff;
      err_in       = err_ff;
      rep_in       = rep_ff;
      last_addr_in = last_addr_ff;
      last_cmd_in  = last_cmd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      addr_in      = addr_ff;
      cmd_in       = cmd_ff;
      if (q_pop) begin
         if (count_ff == '0) begin
            err_in = err_ff || !q_data.lead_ok;
            rep_in = q_data.repeat_ok;
         end else if (count_ff <= BIT_SYMBOLS) begin
            // a symbol fitting both widths counts as a one
            if (q_data.one_ok) begin
               shift_in[bit_idx[4:0]] = 1'b1;
            end else if (q_data.zero_ok) begin
               shift_in[bit_idx[4:0]] = 1'b0;
            end else begin
               err_in = 1'b1;
            end
         end
         if (!q_data.frame_end) begin
            count_in = len;
         end else begin
            rsp_valid_in = 1'b1;
            if (len == FRAME_SYMBOLS && !err_in) begin
               last_addr_in = shift_in[HALF_W-1:0];
               last_cmd_in  = shift_in[2*HALF_W-1:HALF_W];
               status_in    = STATUS_DECODED;
               addr_in      = shift_in[HALF_W-1:0];
               cmd_in       = shift_in[2*HALF_W-1:HALF_W];
            end else if (len == REPEAT_SYMBOLS && rep_in) begin
               status_in = STATUS_REPEAT;
               addr_in   = last_addr_ff;
               cmd_in    = last_cmd_ff;
            end else begin
               status_in = STATUS_REJECTED;
               addr_in   = '0;
               cmd_in    = '0;
            end
            count_in = '0;
            shift_in = '0;
            err_in   = 1'b0;
            rep_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         shift_ff     <= '0;
         err_ff       <= 1'b0;
         rep_ff       <= 1'b0;
         last_addr_ff <= '0;
         last_cmd_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         shift_ff     <= shift_in;
         err_ff       <= err_in;
         rep_ff       <= rep_in;
         last_addr_ff <= last_addr_in;
         last_cmd_ff  <= last_cmd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      addr_ff   <= addr_in;
      cmd_ff    <= cmd_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = status_ff;
   assign rsp_address = addr_ff;
   assign rsp_command = cmd_ff;

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_data.frame_end) |=> (count_ff == '0 && !err_ff && shift_ff == '0))
      else $error("frame state not cleared at frame end");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_data.frame_end) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before it was taken");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == STATUS_REJECTED) |-> (addr_ff == '0 && cmd_ff == '0))
      else $error("rejected frame carries data");

   a_repeat_stored: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == STATUS_REPEAT)
         |-> (addr_ff == last_addr_ff && cmd_ff == last_cmd_ff))
      else $error("repeat result differs from stored frame");

endmodule

// ===== sv/nec_ir_frame_decoder_core.sv =====
// NEC infrared frame decoder.
// Input channel (req_*): one captured symbol per transaction - mark and space
// durations in ticks and req_frame_end on the last symbol of a frame.
// Output channel (rsp_*): one transaction per frame, on its closing symbol:
// status (decoded, repeat, rejected), 16-bit address and 16-bit command.
// csr_*: plain write port for the eight timing registers (margin, lead,
// repeat and bit widths); write only while no frame is in flight.
// Throughput: one symbol per cycle while the queue has room. The front checks
// a symbol against all nominal widths in the cycle it is accepted and pushes
// the verdict into a QUEUE_DEPTH-entry queue; the back pops one entry per
// cycle unless a closing symbol waits on the output, and updates the frame
// state. A closing symbol passes its queue entry, then the output register,
// to rsp_valid; later if stalled or if older symbols still wait in the queue.
// Stall: a held result stops the back at a closing symbol; symbols before it
// keep draining, and req_ready drops once the queue is full.
// Reset (synchronous, active high): timing registers return to their
// defaults, the frame state, stored address/command and queue are cleared.
module nec_ir_frame_decoder_core
   import necirfd_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CFG_IDX_W-1:0] csr_index,
   input  logic [DUR_W-1:0]     csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [DUR_W-1:0]     req_mark_ticks,
   input  logic [DUR_W-1:0]     req_space_ticks,
   input  logic                 req_frame_end,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [HALF_W-1:0]    rsp_address,
   output logic [HALF_W-1:0]    rsp_command
);

   symbol_class_type push_data;
   symbol_class_type head_data;
   logic             push_valid;
   logic             q_full;
   logic             q_valid;
   logic             q_pop;

   // front: timing registers and symbol classification
   necirfd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mark_ticks  (req_mark_ticks),
      .req_space_ticks (req_space_ticks),
      .req_frame_end   (req_frame_end),
      .q_full          (q_full),
      .push_valid      (push_valid),
      .push_data       (push_data)
   );

   // short queue of classified symbols
   necirfd_queue #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH ($bits(symbol_class_type))
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_valid),
      .pop_data   (head_data)
   );

   // back: frame counting, bit gathering, result register
   necirfd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_data      (head_data),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_status  (rsp_status),
      .rsp_address (rsp_address),
      .rsp_command (rsp_command)
   );

endmodule
